>>> rtl/mfwm_pkg.sv
`default_nettype none

package mfwm_pkg;

    localparam int CH_W       = 5;
    localparam int CNT_W      = 16;
    localparam int TIME_W     = 32;
    localparam int FIL_W      = 32;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // Largest channel count the channel field can address
    localparam int CH_SPACE = 1 << CH_W;

    localparam logic [FIL_W-1:0] HOLD_VALUE_Q16 = 32'd1000 << FRAC_W;

    localparam logic [CH_W-1:0] HOLD_INDEX_RESET = 5'd13;
    localparam logic [CNT_W-1:0] HIGH_THRESHOLD_RESET = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MONITOR_ENABLE      = 4'd0,
        REG_FILTER_GAIN         = 4'd1,
        REG_HIGH_THRESHOLD      = 4'd2,
        REG_LOW_THRESHOLD       = 4'd3,
        REG_STARTUP_SECONDS     = 4'd4,
        REG_SIMULATION_MODE     = 4'd5,
        REG_HOLD_CHANNEL_ENABLE = 4'd6,
        REG_HOLD_CHANNEL_INDEX  = 4'd7
    } cfg_reg_t;

    // Result of the filter stage, carried to the compare stage
    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic             wr;
        logic             active;
        logic [FIL_W-1:0] fil;
    } filt_res_t;

endpackage

`default_nettype wire

>>> rtl/mfwm_ram.sv
`default_nettype none

module mfwm_ram #(
    parameter int WIDTH      = 32,
    parameter int DEPTH      = 32,
    parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire logic [ADDR_WIDTH-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]      wr_data,
    input  wire logic [ADDR_WIDTH-1:0] rd_addr,
    output logic      [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/multichannel_feedback_window_monitor_unit.sv
`default_nettype none
// A beat accepted passes the read, filter update and write-back, and window
// compare registers on its way to out_valid. Throughput: one beat per cycle
// unless out_ready stalls; the per-channel filter store is one RAM with a
// registered read, and back-to-back beats on one channel are forwarded.
// Reset: configuration returns to its reset values and every channel's filter
// reads as zero until first written (per-entry flags); no clearing pass.
module multichannel_feedback_window_monitor_unit #(
    parameter int CHANNELS = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               cfg_write,
    input  wire logic [mfwm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mfwm_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [mfwm_pkg::CH_W-1:0]          channel,
    input  wire logic [mfwm_pkg::CNT_W-1:0]         sample_count,
    input  wire logic [mfwm_pkg::TIME_W-1:0]        uptime_seconds,

    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic      [mfwm_pkg::CH_W-1:0]          channel_out,
    output logic      [mfwm_pkg::CNT_W-1:0]         filtered_count,
    output logic                                    above_window,
    output logic                                    below_window,
    output logic                                    alarm,
    output logic                                    check_active
);

    import mfwm_pkg::*;

    localparam int DEPTH = (CHANNELS > CH_SPACE) ? CH_SPACE : CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CH_W:0] CH_LIMIT = (CH_W+1)'(DEPTH);

    // Configuration
    logic                  enable_reg;
    logic [CNT_W-1:0]      gain_reg;
    logic [CNT_W-1:0]      high_reg;
    logic [CNT_W-1:0]      low_reg;
    logic [TIME_W-1:0]     startup_reg;
    logic                  sim_reg;
    logic                  hold_en_reg;
    logic [CH_W-1:0]       hold_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            gain_reg     <= '0;
            high_reg     <= HIGH_THRESHOLD_RESET;
            low_reg      <= '0;
            startup_reg  <= '0;
            sim_reg      <= 1'b0;
            hold_en_reg  <= 1'b0;
            hold_idx_reg <= HOLD_INDEX_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MONITOR_ENABLE:      enable_reg   <= cfg_data[0];
                REG_FILTER_GAIN:         gain_reg     <= cfg_data[CNT_W-1:0];
                REG_HIGH_THRESHOLD:      high_reg     <= cfg_data[CNT_W-1:0];
                REG_LOW_THRESHOLD:       low_reg      <= cfg_data[CNT_W-1:0];
                REG_STARTUP_SECONDS:     startup_reg  <= cfg_data[TIME_W-1:0];
                REG_SIMULATION_MODE:     sim_reg      <= cfg_data[0];
                REG_HOLD_CHANNEL_ENABLE: hold_en_reg  <= cfg_data[0];
                REG_HOLD_CHANNEL_INDEX:  hold_idx_reg <= cfg_data[CH_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline registers
    logic                  p1_valid_reg;
    logic [CH_W-1:0]       p1_channel_reg;
    logic [CNT_W-1:0]      p1_sample_reg;
    logic [TIME_W-1:0]     p1_uptime_reg;

    logic                  p2_valid_reg;
    filt_res_t             p2_reg;
    filt_res_t             p2_next;

    logic                  out_valid_reg;
    logic [CH_W-1:0]       out_channel_reg;
    logic [CNT_W-1:0]      out_count_reg;
    logic                  out_above_reg;
    logic                  out_below_reg;
    logic                  out_active_reg;

    logic [DEPTH-1:0]      written_reg;

    // Handshake: each stage moves when the one after it is free or draining
    logic out_load;
    logic p2_load;
    logic p1_adv;
    logic in_accept;

    assign out_load  = p2_valid_reg && (!out_valid_reg || out_ready);
    assign p2_load   = !p2_valid_reg || out_load;
    assign p1_adv    = p1_valid_reg && p2_load;
    assign in_ready  = !p1_valid_reg || p2_load;
    assign in_accept = in_valid && in_ready;

    // Filter store
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     p1_idx;
    logic [FIL_W-1:0]  ram_rd_data;
    logic              ram_wr_en;

    assign p1_idx  = p1_channel_reg[AW-1:0];
    // Re-read the held beat's entry while stalled so the data stays current
    assign rd_addr = in_accept ? channel[AW-1:0] : p1_idx;

    mfwm_ram #(
        .WIDTH (FIL_W),
        .DEPTH (DEPTH)
    ) u_fil_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (p1_idx),
        .wr_data (p2_next.fil),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // Filter stage
    logic                      in_range;
    logic                      fwd_hit;
    logic                      entry_written;
    logic [FIL_W-1:0]          stored_fil;
    logic signed [FIL_W+1:0]   diff;
    logic signed [FIL_W+CNT_W+2:0] prod;
    logic signed [FIL_W+2:0]   delta;
    logic [FIL_W-1:0]          upd_fil;
    logic                      hold_hit;

    always_comb
    begin
        in_range      = {1'b0, p1_channel_reg} < CH_LIMIT;
        fwd_hit       = p2_valid_reg && p2_reg.wr && (p2_reg.channel == p1_channel_reg);
        entry_written = in_range && written_reg[p1_idx];

        if (fwd_hit)
            stored_fil = p2_reg.fil;
        else if (entry_written)
            stored_fil = ram_rd_data;
        else
            stored_fil = '0;

        diff  = $signed({2'b00, p1_sample_reg, {FRAC_W{1'b0}}})
              - $signed({2'b00, stored_fil});
        prod  = diff * $signed({1'b0, gain_reg});
        // Arithmetic shift floors toward minus infinity
        delta = (FIL_W+3)'(prod >>> FRAC_W);
        upd_fil = stored_fil + delta[FIL_W-1:0];

        hold_hit = hold_en_reg && (p1_channel_reg == hold_idx_reg);

        p2_next.channel = p1_channel_reg;
        p2_next.wr      = in_range && enable_reg;
        p2_next.active  = in_range && enable_reg && !sim_reg
                       && (p1_uptime_reg > startup_reg);
        if (!in_range)
            p2_next.fil = '0;
        else if (!enable_reg)
            p2_next.fil = stored_fil;
        else if (hold_hit)
            p2_next.fil = HOLD_VALUE_Q16;
        else
            p2_next.fil = upd_fil;
    end

    assign ram_wr_en = p1_adv && p2_next.wr;

    // Window compare stage
    logic above_next;
    logic below_next;

    always_comb
    begin
        above_next = p2_reg.active && (p2_reg.fil > {high_reg, {FRAC_W{1'b0}}});
        below_next = p2_reg.active && (p2_reg.fil < {low_reg, {FRAC_W{1'b0}}});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            written_reg   <= '0;
        end
        else
        begin
            if (in_ready)
                p1_valid_reg <= in_valid;
            if (p2_load)
                p2_valid_reg <= p1_valid_reg;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (ram_wr_en)
                written_reg[p1_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            p1_channel_reg <= channel;
            p1_sample_reg  <= sample_count;
            p1_uptime_reg  <= uptime_seconds;
        end
        if (p1_adv)
        begin
            p2_reg <= p2_next;
        end
        if (out_load)
        begin
            out_channel_reg <= p2_reg.channel;
            out_count_reg   <= p2_reg.fil[FIL_W-1:FRAC_W];
            out_above_reg   <= above_next;
            out_below_reg   <= below_next;
            out_active_reg  <= p2_reg.active;
        end
    end

    assign out_valid      = out_valid_reg;
    assign channel_out    = out_channel_reg;
    assign filtered_count = out_count_reg;
    assign above_window   = out_above_reg;
    assign below_window   = out_below_reg;
    assign alarm          = out_above_reg || out_below_reg;
    assign check_active   = out_active_reg;

endmodule

`default_nettype wire
